[rtl/assert_macros.svh]
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define QLTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// Next-cycle implication, switched off while reset is high.
`define QLTD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[rtl/qltd_pkg.sv]
// ----------------------------------------------------------------------------
// Q(lambda) TD update package
// Shared types, widths and reset constants of the TD update block.
// ----------------------------------------------------------------------------
package qltd_pkg;

   localparam int DEF_NUM_STATES  = 64;
   localparam int DEF_NUM_ACTIONS = 4;
   localparam int DEF_INIT_VALUE  = 0;

   localparam int VALUE_W = 16;
   localparam int TRACE_W = 17;
   localparam int TD_W    = 18;
   localparam int CSR_IDX_W = 8;

   localparam logic [15:0] DISCOUNT_RST   = 16'd62259;
   localparam logic [15:0] DECAY_RST      = 16'd58982;
   localparam logic [15:0] RATE_RST       = 16'd6554;
   localparam logic [15:0] BASELINE_RST   = 16'd0;
   localparam logic [TRACE_W-1:0] TRACE_ONE = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISCOUNT = 8'd0,
      CSR_DECAY    = 8'd1,
      CSR_RATE     = 8'd2,
      CSR_BASELINE = 8'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN,
      ST_MUL,
      ST_TD,
      ST_ATD,
      ST_SWEEP,
      ST_DONE
   } state_type;

endpackage

[rtl/qltd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qltd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/q_lambda_td_update.sv]
// One request at a time. An item with no stored pair goes from acceptance to result
// without touching the table; one with a stored pair updates the table in the single
// sweep over both memories. Either may then wait for the result register to free up,
// and an out-of-range index first adds a reduction by repeated subtraction. Reset is
// synchronous, active high, and is followed by a fill of the value table.
// ----------------------------------------------------------------------------
// Q(lambda) TD update
// Scans the reached state's action values, forms the TD error against the
// stored pair and, if one is held, applies a fused trace decay and value update to the table.
// ----------------------------------------------------------------------------
module q_lambda_td_update #(
   parameter int NUM_STATES  = qltd_pkg::DEF_NUM_STATES,
   parameter int NUM_ACTIONS = qltd_pkg::DEF_NUM_ACTIONS,
   parameter int INIT_VALUE  = qltd_pkg::DEF_INIT_VALUE
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // reward[15:0], reached_state[21:16], chosen_action[23:22]
   input  logic        req_tuser,   // episode_start
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // td_error[17:0], zero padding[23:18]
   output logic        rsp_tuser,   // updated
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [qltd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import qltd_pkg::*;

   localparam int TS = NUM_STATES * NUM_ACTIONS;
   localparam int AW = (TS > 1) ? $clog2(TS) : 1;
   localparam int CW = $clog2(TS + 1);
   localparam int KW = $clog2(NUM_ACTIONS + 2);
   localparam logic [VALUE_W-1:0] INIT_Q = VALUE_W'(INIT_VALUE);

   // Configuration registers. The port never stalls a write.
   logic [15:0] discount_ff, decay_ff, rate_ff, baseline_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= DISCOUNT_RST;
         decay_ff    <= DECAY_RST;
         rate_ff     <= RATE_RST;
         baseline_ff <= BASELINE_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_DISCOUNT) discount_ff <= csr_data;
         if (csr_index == CSR_DECAY)    decay_ff    <= csr_data;
         if (csr_index == CSR_RATE)     rate_ff     <= csr_data;
         if (csr_index == CSR_BASELINE) baseline_ff <= csr_data;
      end
   end

   // Control and working registers.
   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] k_ff, k_in;
   logic rd_v_ff, rd_v_in;
   logic [KW-1:0] rd_k_ff;
   logic [AW-1:0] rd_a_ff;
   logic s1_v_ff, s2_v_ff;
   logic prev_v_ff, prev_v_in;
   logic clr_tr_ff, clr_tr_in;
   logic [AW-1:0] prev_a_ff, prev_a_in;
   logic rsp_v_ff, rsp_v_in;

   // Payload registers.
   logic signed [15:0] reward_ff;
   logic [5:0] ns_ff, ns_in;
   logic [1:0] na_ff, na_in;
   logic signed [15:0] qmax_ff, qprev_ff;
   logic signed [32:0] dprod_ff;
   logic signed [TD_W-1:0] td_ff;
   logic signed [33:0] atd_ff;
   logic [TD_W-1:0] rsp_td_ff;
   logic rsp_upd_ff;

   // Memories.
   logic q_we, t_we;
   logic [AW-1:0] q_wa, rd_addr;
   logic [VALUE_W-1:0] q_wd, q_rd;
   logic [TRACE_W-1:0] t_rd;

   qltd_ram #(.WIDTH(VALUE_W), .DEPTH(TS), .AW(AW)) u_qram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(rd_addr), .rd_data(q_rd)
   );

   // Sweep pipeline: stage 1 decays the trace, stage 2 scales it by
   // alpha*TD, and the write-back adds the delta with saturation.
   logic [TRACE_W-1:0] s1_t_ff, s2_t_ff;
   logic [VALUE_W-1:0] s1_q_ff, s2_q_ff;
   logic [AW-1:0] s1_a_ff, s2_a_ff;
   logic signed [34:0] s2_hi_ff;
   logic [33:0] s2_lo_ff;

   qltd_ram #(.WIDTH(TRACE_W), .DEPTH(TS), .AW(AW)) u_tram (
      .clock(clock), .wr_en(t_we), .wr_addr(s2_a_ff), .wr_data(s2_t_ff),
      .rd_addr(rd_addr), .rd_data(t_rd)
   );

   logic [32:0] tdec;
   logic [TRACE_W-1:0] t_new;
   logic signed [51:0] full;
   logic signed [19:0] delta;
   logic signed [20:0] qsum;
   logic [VALUE_W-1:0] qsat;

   always_comb begin
      tdec = 33'(t_rd) * 33'(decay_ff);
      if (rd_a_ff == prev_a_ff) begin
         t_new = TRACE_ONE;
      end else if (clr_tr_ff) begin
         t_new = '0;
      end else begin
         t_new = tdec[32:16];
      end
      full = ($signed({{17{s2_hi_ff[34]}}, s2_hi_ff}) <<< 17)
           + $signed({18'd0, s2_lo_ff});
      delta = full[51:32];
      qsum = {{5{s2_q_ff[15]}}, s2_q_ff} + {delta[19], delta};
      if (qsum > 21'sd32767) begin
         qsat = 16'h7fff;
      end else if (qsum < -21'sd32768) begin
         qsat = 16'h8000;
      end else begin
         qsat = qsum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rd_v_ff && (state_ff == ST_SWEEP);
         s2_v_ff <= s1_v_ff;
      end
      s1_t_ff  <= t_new;
      s1_q_ff  <= q_rd;
      s1_a_ff  <= rd_a_ff;
      s2_t_ff  <= s1_t_ff;
      s2_q_ff  <= s1_q_ff;
      s2_a_ff  <= s1_a_ff;
      s2_hi_ff <= 35'($signed({1'b0, s1_t_ff})) * 35'($signed(atd_ff[33:17]));
      s2_lo_ff <= 34'(s1_t_ff) * 34'(atd_ff[16:0]);
   end

   // Target and TD arithmetic for the states that use them.
   logic signed [18:0] tgt, td_full;

   always_comb begin
      tgt = {{3{reward_ff[15]}}, reward_ff} - {{3{baseline_ff[15]}}, baseline_ff}
          + 19'(dprod_ff >>> 16);
      td_full = tgt - {{3{qprev_ff[15]}}, qprev_ff};
   end

   // Main sequencer: next state and outputs.
   logic base_sel;
   logic [AW-1:0] base_a;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      rd_v_in   = 1'b0;
      rd_addr   = cnt_ff[AW-1:0];
      prev_v_in = prev_v_ff;
      prev_a_in = prev_a_ff;
      clr_tr_in = clr_tr_ff;
      rsp_v_in  = rsp_v_ff && !rsp_tready;
      ns_in     = ns_ff;
      na_in     = na_ff;
      q_we      = 1'b0;
      q_wa      = s2_a_ff;
      q_wd      = qsat;
      t_we      = 1'b0;
      req_tready = 1'b0;
      base_a    = AW'(32'(ns_ff) * NUM_ACTIONS);
      base_sel  = (32'(k_ff) < NUM_ACTIONS);
      unique case (state_ff)
         ST_CLEAR: begin
            q_we   = 1'b1;
            q_wa   = cnt_ff[AW-1:0];
            q_wd   = INIT_Q;
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == TS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            ns_in = req_tdata[21:16];
            na_in = req_tdata[23:22];
            if (req_tvalid) begin
               state_in = ST_REDUCE;
               if (req_tuser) begin
                  prev_v_in = 1'b0;
                  clr_tr_in = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            // Out-of-range indexes wrap by repeated subtraction.
            if (32'(ns_ff) >= NUM_STATES) begin
               ns_in = ns_ff - 6'(NUM_STATES);
            end
            if (32'(na_ff) >= NUM_ACTIONS) begin
               na_in = na_ff - 2'(NUM_ACTIONS);
            end
            if (32'(ns_ff) < NUM_STATES && 32'(na_ff) < NUM_ACTIONS) begin
               state_in = ST_SCAN;
               k_in = '0;
            end
         end
         ST_SCAN: begin
            // Reads the reached state's actions, then the stored pair.
            if (base_sel) begin
               rd_addr = base_a + AW'(k_ff);
            end else begin
               rd_addr = prev_a_ff;
            end
            rd_v_in = (32'(k_ff) <= NUM_ACTIONS);
            k_in = k_ff + 1'b1;
            if (32'(k_ff) == NUM_ACTIONS + 1) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_TD;
         end
         ST_TD: begin
            state_in = prev_v_ff ? ST_ATD : ST_DONE;
            cnt_in = '0;
         end
         ST_ATD: begin
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            q_we = s2_v_ff;
            t_we = s2_v_ff;
            if (32'(cnt_ff) < TS) begin
               rd_v_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!rd_v_ff && !s1_v_ff && !s2_v_ff) begin
               clr_tr_in = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in  = 1'b1;
               prev_v_in = 1'b1;
               prev_a_in = base_a + AW'(na_ff);
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         k_ff      <= '0;
         rd_v_ff   <= 1'b0;
         prev_v_ff <= 1'b0;
         prev_a_ff <= '0;
         clr_tr_ff <= 1'b1;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         k_ff      <= k_in;
         rd_v_ff   <= rd_v_in;
         prev_v_ff <= prev_v_in;
         prev_a_ff <= prev_a_in;
         clr_tr_ff <= clr_tr_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ns_ff   <= ns_in;
      na_ff   <= na_in;
      rd_k_ff <= k_ff;
      rd_a_ff <= rd_addr;
      if (state_ff == ST_IDLE) begin
         reward_ff <= req_tdata[15:0];
      end
      if (rd_v_ff && state_ff == ST_SCAN) begin
         if (rd_k_ff == '0) begin
            qmax_ff <= q_rd;
         end else if (32'(rd_k_ff) < NUM_ACTIONS) begin
            if ($signed(q_rd) > qmax_ff) begin
               qmax_ff <= q_rd;
            end
         end else begin
            qprev_ff <= q_rd;
         end
      end
      if (state_ff == ST_MUL) begin
         dprod_ff <= 33'($signed({1'b0, discount_ff})) * 33'(qmax_ff);
      end
      if (state_ff == ST_TD) begin
         td_ff <= prev_v_ff ? td_full[TD_W-1:0] : '0;
      end
      if (state_ff == ST_ATD) begin
         atd_ff <= 34'($signed({1'b0, rate_ff})) * 34'(td_ff);
      end
      if (state_ff == ST_DONE && (!rsp_v_ff || rsp_tready)) begin
         rsp_td_ff  <= td_ff;
         rsp_upd_ff <= prev_v_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'd0, rsp_td_ff};
   assign rsp_tuser  = rsp_upd_ff;

endmodule

[rtl/qltd_checker.sv]
// ----------------------------------------------------------------------------
// TD update port checker
// Watches the ports of the TD update block and flags illegal behaviour.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qltd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled response keeps its payload.
   `QLTD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Without an update the TD error and padding are zero.
   `QLTD_ASSERT_IMP(a_td_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 24'd0)

   // The table is still being initialised just after reset.
   `QLTD_ASSERT_IMP(a_clear_busy, clock, reset, $fell(reset), !req_tready)

   // One request at a time: no acceptance in the cycle after one.
   `QLTD_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind q_lambda_td_update qltd_checker u_qltd_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
